// ===== rtl/sqvs_pkg.sv =====
// Shared types, register indexes and constants for the sprite quad vertex setup.
// No dependencies.
package sqvs_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QuotW   = 18;
  localparam int unsigned DivW    = 13;
  // texture numerator: (2*src + 2*size - 1) * 32768 needs 30 magnitude bits plus sign
  localparam int unsigned NumW      = 31;
  localparam int unsigned DivBits   = 30;
  localparam int unsigned DivBps    = 3;
  localparam int unsigned DivStages = 10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAT_XX  = 3'd0,
    REG_MAT_XY  = 3'd1,
    REG_MAT_YX  = 3'd2,
    REG_MAT_YY  = 3'd3,
    REG_TRANS_X = 3'd4,
    REG_TRANS_Y = 3'd5,
    REG_ATLAS_W = 3'd6,
    REG_ATLAS_H = 3'd7
  } cfg_reg_t;

  localparam logic signed [20:0] PosMin = -21'sd1048576;
  localparam logic signed [20:0] PosMax = 21'sd1048575;
  localparam logic signed [17:0] TexMin = -18'sd131072;
  localparam logic signed [17:0] TexMax = 18'sd131071;

  // sprite request as it travels with the vertex phase
  typedef struct packed {
    logic              mirror;
    logic signed [16:0] xl;
    logic signed [16:0] xr;
    logic signed [16:0] yb;
    logic signed [16:0] yt;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } quad_t;

  // numerators of the four texture divides
  typedef struct packed {
    logic signed [NumW-1:0] sl;
    logic signed [NumW-1:0] sr;
    logic signed [NumW-1:0] tt;
    logic signed [NumW-1:0] tb;
  } tex_num_t;

  typedef struct packed {
    logic signed [17:0] sl;
    logic signed [17:0] sr;
    logic signed [17:0] tt;
    logic signed [17:0] tb;
  } tex_coord_t;

endpackage

// ===== rtl/sprite_quad_vertex_setup.sv =====
// Top level of the sprite quad vertex setup; instantiates sqvs_div and sqvs_xform.
// Uses sqvs_pkg for register indexes, types and limits.
// Each sprite's vertices leave one per cycle on the result port.
// busy rises after a transfer and holds off new sprites so that the four vertices
// of each sprite can share the one result port.
// Reset: synchronous active-low rst_n restores register defaults, clears all valids.
// Results cannot be stalled by the receiver.
module sprite_quad_vertex_setup (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [11:0]        in_src_x,
  input  logic [11:0]        in_src_y,
  input  logic [12:0]        in_src_w,
  input  logic [12:0]        in_src_h,
  input  logic signed [15:0] in_dst_x,
  input  logic signed [15:0] in_dst_y,
  input  logic signed [15:0] in_dst_w,
  input  logic signed [15:0] in_dst_h,
  input  logic [31:0]        in_color_rgba,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_strobe,
  output logic [1:0]         out_corner,
  output logic signed [20:0] out_screen_x,
  output logic signed [20:0] out_screen_y,
  output logic signed [17:0] out_tex_s,
  output logic signed [17:0] out_tex_t,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic               out_last
);
  localparam int unsigned DivLat = sqvs_pkg::DivStages;
  localparam int unsigned XfLat  = 3;

  logic signed [31:0] mat_xx_r, mat_xy_r, mat_yx_r, mat_yy_r, trans_x_r, trans_y_r;
  logic [12:0]        atlas_w_r, atlas_h_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_xx_r <= 32'sd65536; mat_xy_r <= '0; mat_yx_r <= '0; mat_yy_r <= 32'sd65536;
      trans_x_r <= '0; trans_y_r <= '0; atlas_w_r <= 13'd1024; atlas_h_r <= 13'd1024;
    end else if (cfg_valid) begin
      case (sqvs_pkg::cfg_reg_t'(cfg_index))
        sqvs_pkg::REG_MAT_XX:  mat_xx_r  <= cfg_data;
        sqvs_pkg::REG_MAT_XY:  mat_xy_r  <= cfg_data;
        sqvs_pkg::REG_MAT_YX:  mat_yx_r  <= cfg_data;
        sqvs_pkg::REG_MAT_YY:  mat_yy_r  <= cfg_data;
        sqvs_pkg::REG_TRANS_X: trans_x_r <= cfg_data;
        sqvs_pkg::REG_TRANS_Y: trans_y_r <= cfg_data;
        sqvs_pkg::REG_ATLAS_W: atlas_w_r <= cfg_data[12:0];
        sqvs_pkg::REG_ATLAS_H: atlas_h_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // ---- stage 0: accept, compute edges, numerators, premultiplied color
  logic accept;
  logic [1:0] hold_r, hold_nxt;
  assign busy   = (hold_r != 2'd0);
  assign accept = start && !busy;
  always_comb hold_nxt = accept ? 2'd3 : (busy ? hold_r - 2'd1 : 2'd0);
  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= '0;
    else        hold_r <= hold_nxt;
  end

  logic                s0_vld_r;
  sqvs_pkg::quad_t     s0_q_r;
  sqvs_pkg::tex_num_t  s0_n_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else        s0_vld_r <= accept;
    if (accept) begin
      s0_q_r.mirror <= in_func;
      s0_q_r.xl     <= 17'(in_dst_x);
      s0_q_r.xr     <= 17'(in_dst_x) + 17'(in_dst_w);
      s0_q_r.yb     <= 17'(in_dst_y);
      s0_q_r.yt     <= 17'(in_dst_y) + 17'(in_dst_h);
      s0_q_r.red    <= 8'((16'(in_color_rgba[31:24]) * 16'(in_color_rgba[7:0])) >> 8);
      s0_q_r.green  <= 8'((16'(in_color_rgba[23:16]) * 16'(in_color_rgba[7:0])) >> 8);
      s0_q_r.blue   <= 8'((16'(in_color_rgba[15:8])  * 16'(in_color_rgba[7:0])) >> 8);
      s0_q_r.alpha  <= in_color_rgba[7:0];
      s0_n_r.sl <= $signed({18'b0, in_src_x, 1'b1}) <<< 15;
      s0_n_r.sr <= ($signed({18'b0, in_src_x, 1'b0}) + $signed({17'b0, in_src_w, 1'b0})
                    - 31'sd1) <<< 15;
      s0_n_r.tt <= $signed({18'b0, in_src_y, 1'b1}) <<< 15;
      s0_n_r.tb <= ($signed({18'b0, in_src_y, 1'b0}) + $signed({17'b0, in_src_h, 1'b0})
                    - 31'sd1) <<< 15;
    end
  end

  // ---- texture divides (four lanes)
  sqvs_pkg::tex_coord_t tc;
  logic [3:0] dv;
  sqvs_div u_div_sl (.clk, .rst_n, .in_vld(s0_vld_r), .num(s0_n_r.sl), .den(atlas_w_r),
                     .out_vld(dv[0]), .quo(tc.sl));
  sqvs_div u_div_sr (.clk, .rst_n, .in_vld(s0_vld_r), .num(s0_n_r.sr), .den(atlas_w_r),
                     .out_vld(dv[1]), .quo(tc.sr));
  sqvs_div u_div_tt (.clk, .rst_n, .in_vld(s0_vld_r), .num(s0_n_r.tt), .den(atlas_h_r),
                     .out_vld(dv[2]), .quo(tc.tt));
  sqvs_div u_div_tb (.clk, .rst_n, .in_vld(s0_vld_r), .num(s0_n_r.tb), .den(atlas_h_r),
                     .out_vld(dv[3]), .quo(tc.tb));

  sqvs_pkg::quad_t q_dly_r [DivLat];
  always_ff @(posedge clk) begin
    q_dly_r[0] <= s0_q_r;
    for (int i = 1; i < DivLat; i++) q_dly_r[i] <= q_dly_r[i-1];
  end

  // ---- vertex issue: latch quad, emit corners 0..3
  sqvs_pkg::quad_t      iq_r;
  sqvs_pkg::tex_coord_t itc_r;
  logic [1:0]           k_r;
  logic                 iss_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= 1'b0; k_r <= '0;
    end else if (dv[0]) begin
      iss_r <= 1'b1; k_r <= '0;
    end else if (iss_r) begin
      k_r <= k_r + 2'd1;
      if (k_r == 2'd3) iss_r <= 1'b0;
    end
    if (dv[0]) begin
      iq_r  <= q_dly_r[DivLat-1];
      itc_r <= tc;
    end
  end

  logic               right, top;
  logic signed [16:0] vx, vy;
  assign right = k_r[0];
  assign top   = k_r[1];
  assign vx = (right ^ iq_r.mirror) ? iq_r.xr : iq_r.xl;
  assign vy = top ? iq_r.yt : iq_r.yb;

  logic signed [20:0] pos_x, pos_y;
  sqvs_xform u_xf_x (.clk, .x(vx), .y(vy), .ax(mat_xx_r), .ay(mat_yx_r), .tr(trans_x_r),
                     .pos(pos_x));
  sqvs_xform u_xf_y (.clk, .x(vx), .y(vy), .ax(mat_xy_r), .ay(mat_yy_r), .tr(trans_y_r),
                     .pos(pos_y));

  logic [XfLat-1:0]   v_dly_r;
  logic [1:0]         k_dly_r  [XfLat];
  logic signed [17:0] s_dly_r  [XfLat];
  logic signed [17:0] t_dly_r  [XfLat];
  logic [31:0]        c_dly_r  [XfLat];
  always_ff @(posedge clk) begin
    if (!rst_n) v_dly_r <= '0;
    else        v_dly_r <= {v_dly_r[XfLat-2:0], iss_r};
    k_dly_r[0] <= k_r;
    s_dly_r[0] <= right ? itc_r.sr : itc_r.sl;
    t_dly_r[0] <= top ? itc_r.tt : itc_r.tb;
    c_dly_r[0] <= {iq_r.red, iq_r.green, iq_r.blue, iq_r.alpha};
    for (int i = 1; i < XfLat; i++) begin
      k_dly_r[i] <= k_dly_r[i-1];
      s_dly_r[i] <= s_dly_r[i-1];
      t_dly_r[i] <= t_dly_r[i-1];
      c_dly_r[i] <= c_dly_r[i-1];
    end
  end

  assign out_strobe   = v_dly_r[XfLat-1];
  assign out_corner   = k_dly_r[XfLat-1];
  assign out_screen_x = pos_x;
  assign out_screen_y = pos_y;
  assign out_tex_s    = s_dly_r[XfLat-1];
  assign out_tex_t    = t_dly_r[XfLat-1];
  assign out_red      = c_dly_r[XfLat-1][31:24];
  assign out_green    = c_dly_r[XfLat-1][23:16];
  assign out_blue     = c_dly_r[XfLat-1][15:8];
  assign out_alpha    = c_dly_r[XfLat-1][7:0];
  assign out_last     = out_strobe && (out_corner == 2'd3);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy not raised after start");
  a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe && out_corner == $past(out_corner) + 2'd1)
    else $error("corner sequence broken");
  a_last_only_3: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_corner == 2'd3) else $error("last off corner 3");
  a_div_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    dv == 4'b0000 || dv == 4'b1111) else $error("divide lanes out of step");
endmodule

// ===== rtl/sqvs_div.sv =====
// Pipelined signed divide by unsigned 13-bit divisor with saturation to 18 bits.
// Restoring divide on the magnitude, a few quotient bits per stage; uses sqvs_pkg.
module sqvs_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic signed [sqvs_pkg::NumW-1:0]    num,
  input  logic [sqvs_pkg::DivW-1:0]           den,
  output logic                                out_vld,
  output logic signed [sqvs_pkg::QuotW-1:0]   quo
);
  localparam int unsigned NB  = sqvs_pkg::DivBits;
  localparam int unsigned BPS = sqvs_pkg::DivBps;
  localparam int unsigned NS  = sqvs_pkg::DivStages;
  localparam int unsigned DW  = sqvs_pkg::DivW;
  localparam int unsigned NW  = sqvs_pkg::NumW;

  logic [NB-1:0] mag0;
  logic [DW-1:0] den0;
  assign mag0 = num[NW-1] ? NB'(-num) : NB'(num);
  // zero atlas size divides by one
  assign den0 = (den == '0) ? DW'(1) : den;

  logic          vld_r [NS];
  logic [NB-1:0] q_r   [NS];
  logic [DW:0]   rem_r [NS];
  logic [DW-1:0] den_r [NS];
  logic          neg_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic          vld_in, neg_in;
    logic [NB-1:0] q_in, q_nxt;
    logic [DW:0]   r_in, r_nxt;
    logic [DW-1:0] d_in;
    if (s == 0) begin : g_head
      assign vld_in = in_vld;
      assign q_in   = mag0;
      assign r_in   = '0;
      assign d_in   = den0;
      assign neg_in = num[NW-1];
    end else begin : g_tail
      assign vld_in = vld_r[s-1];
      assign q_in   = q_r[s-1];
      assign r_in   = rem_r[s-1];
      assign d_in   = den_r[s-1];
      assign neg_in = neg_r[s-1];
    end
    always_comb begin
      logic [DW+1:0] t;
      q_nxt = q_in;
      r_nxt = r_in;
      for (int b = 0; b < BPS; b++) begin
        t = {r_nxt, q_nxt[NB-1]};
        q_nxt = {q_nxt[NB-2:0], 1'b0};
        if (t >= {2'b0, d_in}) begin
          t = t - {2'b0, d_in};
          q_nxt[0] = 1'b1;
        end
        r_nxt = t[DW:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else        vld_r[s] <= vld_in;
      q_r[s]   <= q_nxt;
      rem_r[s] <= r_nxt;
      den_r[s] <= d_in;
      neg_r[s] <= neg_in;
    end
  end

  logic [NB-1:0] q;
  assign q = q_r[NS-1];
  always_comb begin
    if (neg_r[NS-1]) quo = (q > NB'(131072)) ? sqvs_pkg::TexMin : 18'(-$signed({1'b0, q}));
    else             quo = (q > NB'(131071)) ? sqvs_pkg::TexMax : 18'(q);
  end
  assign out_vld = vld_r[NS-1];
endmodule

// ===== rtl/sqvs_xform.sv =====
// Affine transform of one vertex: two products per axis, sum, truncate, saturate.
// Three register stages; uses sqvs_pkg.
module sqvs_xform (
  input  logic               clk,
  input  logic signed [16:0] x,
  input  logic signed [16:0] y,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] tr,
  output logic signed [20:0] pos
);
  logic signed [48:0] px_r, py_r;
  logic signed [31:0] tr_r;
  logic signed [50:0] sum_r;
  logic signed [34:0] q_r;

  always_ff @(posedge clk) begin
    px_r  <= x * ax;
    py_r  <= y * ay;
    tr_r  <= tr;
    sum_r <= 51'(px_r) + 51'(py_r) + 51'(tr_r);
    // truncate toward zero: add 65535 for negatives before the shift
    q_r   <= 35'((sum_r + (sum_r[50] ? 51'sd65535 : 51'sd0)) >>> 16);
  end

  always_comb begin
    if (q_r > 35'(sqvs_pkg::PosMax))      pos = sqvs_pkg::PosMax;
    else if (q_r < 35'(sqvs_pkg::PosMin)) pos = sqvs_pkg::PosMin;
    else                                  pos = q_r[20:0];
  end
endmodule

// ===== verif/sprite_quad_vertex_setup_test.sv =====
// Self-checking testbench for sprite_quad_vertex_setup: drives sprite requests and
// matrix/atlas register writes, predicts the four corner vertices of each sprite.
// Depends on sqvs_pkg and the sprite_quad_vertex_setup RTL.
`timescale 1ns / 1ps

module sprite_quad_vertex_setup_test;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [20:0] sx;
    logic signed [20:0] sy;
    logic signed [17:0] ts;
    logic signed [17:0] tt;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         a;
    logic               last;
  } vertex_t;

  localparam int WatchdogLimit = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_func = 1'b0;
  logic [11:0]        in_src_x = '0;
  logic [11:0]        in_src_y = '0;
  logic [12:0]        in_src_w = '0;
  logic [12:0]        in_src_h = '0;
  logic signed [15:0] in_dst_x = '0;
  logic signed [15:0] in_dst_y = '0;
  logic signed [15:0] in_dst_w = '0;
  logic signed [15:0] in_dst_h = '0;
  logic [31:0]        in_color_rgba = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               out_strobe;
  logic [1:0]         out_corner;
  logic signed [20:0] out_screen_x;
  logic signed [20:0] out_screen_y;
  logic signed [17:0] out_tex_s;
  logic signed [17:0] out_tex_t;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic [7:0]         out_alpha;
  logic               out_last;

  // model copy of the register file
  logic signed [31:0] m_xx, m_xy, m_yx, m_yy, m_tx, m_ty;
  logic [12:0]        atl_w, atl_h;

  vertex_t vertex_q[$];
  int      mismatches = 0;
  int      idle_cycles = 0;

  always #5 clk = ~clk;

  sprite_quad_vertex_setup u_dut (.*);

  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [17:0] tex_clamp(longint num, logic [12:0] size);
    longint d, q;
    d = (size == 0) ? 1 : size;
    q = (num * 32768) / d;
    if (q < sqvs_pkg::TexMin) q = sqvs_pkg::TexMin;
    if (q > sqvs_pkg::TexMax) q = sqvs_pkg::TexMax;
    return q[17:0];
  endfunction

  function automatic logic signed [20:0] pos_clamp(longint v);
    longint q;
    q = v / 65536;
    if (q < sqvs_pkg::PosMin) q = sqvs_pkg::PosMin;
    if (q > sqvs_pkg::PosMax) q = sqvs_pkg::PosMax;
    return q[20:0];
  endfunction

  task automatic predict_quad(logic mir, logic [11:0] sx, logic [11:0] sy,
                              logic [12:0] sw, logic [12:0] sh,
                              logic signed [15:0] dx, logic signed [15:0] dy,
                              logic signed [15:0] dw, logic signed [15:0] dh,
                              logic [31:0] col);
    longint xl, xr, yb, yt, x, y, tmp;
    logic signed [17:0] s_l, s_r, t_t, t_b;
    logic [7:0] a;
    vertex_t v;
    xl = dx; xr = longint'(dx) + dw; yb = dy; yt = longint'(dy) + dh;
    s_l = tex_clamp(2 * longint'(sx) + 1, atl_w);
    s_r = tex_clamp(2 * longint'(sx) + 2 * longint'(sw) - 1, atl_w);
    t_t = tex_clamp(2 * longint'(sy) + 1, atl_h);
    t_b = tex_clamp(2 * longint'(sy) + 2 * longint'(sh) - 1, atl_h);
    a = col[7:0];
    if (mir) begin
      tmp = xl; xl = xr; xr = tmp;
    end
    for (int k = 0; k < 4; k++) begin
      x = k[0] ? xr : xl;
      y = k[1] ? yt : yb;
      v.corner = k[1:0];
      v.sx = pos_clamp(x * m_xx + y * m_yx + m_tx);
      v.sy = pos_clamp(x * m_xy + y * m_yy + m_ty);
      v.ts = k[0] ? s_r : s_l;
      v.tt = k[1] ? t_t : t_b;
      v.r = 8'((16'(col[31:24]) * 16'(a)) >> 8);
      v.g = 8'((16'(col[23:16]) * 16'(a)) >> 8);
      v.b = 8'((16'(col[15:8]) * 16'(a)) >> 8);
      v.a = a;
      v.last = (k == 3);
      vertex_q.push_back(v);
    end
  endtask

  always @(posedge clk) begin
    vertex_t got, want;
    if (rst_n && out_strobe) begin
      got = {out_corner, out_screen_x, out_screen_y, out_tex_s, out_tex_t,
             out_red, out_green, out_blue, out_alpha, out_last};
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %p", got);
      end else begin
        want = vertex_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("vertex mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  // called just after a falling edge; returns just after a falling edge with start
  // possibly still high, which is safe while busy covers the following cycles
  task automatic send_sprite(logic mir, logic [11:0] sx, logic [11:0] sy,
                             logic [12:0] sw, logic [12:0] sh,
                             logic signed [15:0] dx, logic signed [15:0] dy,
                             logic signed [15:0] dw, logic signed [15:0] dh,
                             logic [31:0] col);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func <= mir; in_src_x <= sx; in_src_y <= sy; in_src_w <= sw; in_src_h <= sh;
    in_dst_x <= dx; in_dst_y <= dy; in_dst_w <= dw; in_dst_h <= dh;
    in_color_rgba <= col;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_quad(mir, sx, sy, sw, sh, dx, dy, dw, dh, col);
    @(negedge clk);
  endtask

  task automatic send_random_sprite();
    logic [12:0] sw, sh;
    sw = ($urandom_range(0, 9) == 0) ? 13'd4096 : 13'($urandom_range(0, 8191));
    sh = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(0, 8191));
    send_sprite(1'($urandom), 12'($urandom), 12'($urandom), sw, sh,
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic write_reg(sqvs_pkg::cfg_reg_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sqvs_pkg::REG_MAT_XX:  m_xx = data;
      sqvs_pkg::REG_MAT_XY:  m_xy = data;
      sqvs_pkg::REG_MAT_YX:  m_yx = data;
      sqvs_pkg::REG_MAT_YY:  m_yy = data;
      sqvs_pkg::REG_TRANS_X: m_tx = data;
      sqvs_pkg::REG_TRANS_Y: m_ty = data;
      sqvs_pkg::REG_ATLAS_W: atl_w = data[12:0];
      sqvs_pkg::REG_ATLAS_H: atl_h = data[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // called just after a falling edge, after the last send
  task automatic drain();
    start <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_matrix(logic [31:0] xx, logic [31:0] xy, logic [31:0] yx,
                             logic [31:0] yy, logic [31:0] tx, logic [31:0] ty,
                             logic [31:0] aw, logic [31:0] ah);
    drain();
    write_reg(sqvs_pkg::REG_MAT_XX, xx);
    write_reg(sqvs_pkg::REG_MAT_XY, xy);
    write_reg(sqvs_pkg::REG_MAT_YX, yx);
    write_reg(sqvs_pkg::REG_MAT_YY, yy);
    write_reg(sqvs_pkg::REG_TRANS_X, tx);
    write_reg(sqvs_pkg::REG_TRANS_Y, ty);
    write_reg(sqvs_pkg::REG_ATLAS_W, aw);
    write_reg(sqvs_pkg::REG_ATLAS_H, ah);
  endtask

  task automatic test_identity_directed();
    send_sprite(1'b0, 12'd0, 12'd0, 13'd16, 13'd16, 16'sd10, 16'sd20, 16'sd30, 16'sd40,
                32'hFF80_40FF);
    send_sprite(1'b1, 12'd100, 12'd50, 13'd8, 13'd4, -16'sd5, 16'sd7, 16'sd12, -16'sd3,
                32'h1234_5680);
    send_sprite(1'b0, 12'hFFF, 12'hFFF, 13'd4096, 13'd4096, 16'h7FFF, 16'h7FFF,
                16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
    send_sprite(1'b1, 12'd0, 12'd0, 13'd0, 13'd0, 16'h8000, 16'h8000, 16'h8000,
                16'h8000, 32'h0000_0000);
    // source size beyond its range, empty source rectangle
    send_sprite(1'b0, 12'd5, 12'd9, 13'h1FFF, 13'd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1,
                32'hAA55_AA01);
  endtask

  task automatic test_extreme_matrix();
    // largest coefficients force position saturation both ways
    load_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd4096);
    send_sprite(1'b0, 12'hFFF, 12'd0, 13'd4096, 13'd1, 16'h7FFF, 16'h7FFF, 16'sd0,
                16'h8000, 32'hFF00_FF80);
    send_sprite(1'b1, 12'd1, 12'hFFF, 13'd2, 13'd4096, 16'h8000, 16'sd1, 16'h7FFF,
                16'sd2, 32'h00FF_00FF);
    // zero atlas treated as one, oversized atlas uses raw bits
    load_matrix(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000,
                32'h0000_7FFF, 32'hFFFF_0001, 32'd0, 32'h1FFF);
    send_sprite(1'b0, 12'd3, 12'd3, 13'd3, 13'd3, -16'sd1, -16'sd1, 16'sd3, 16'sd3,
                32'h8080_8080);
    send_sprite(1'b1, 12'hFFF, 12'hFFF, 13'h1FFF, 13'h1FFF, 16'sd100, -16'sd100,
                -16'sd50, 16'sd50, 32'hFFFF_FF01);
  endtask

  task automatic test_random_sprites(int n);
    for (int i = 0; i < n; i++) send_random_sprite();
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 4; p++) begin
      load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 8191), $urandom_range(1, 4096));
      test_random_sprites(40);
    end
    // back to a near-identity, realistic screen setup
    load_matrix(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
                32'h0010_0000, 32'hFFF0_0000, 32'd1024, 32'd512);
    test_random_sprites(80);
  endtask

  initial begin
    m_xx = 32'sd65536; m_xy = 0; m_yx = 0; m_yy = 32'sd65536; m_tx = 0; m_ty = 0;
    atl_w = 13'd1024; atl_h = 13'd1024;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_identity_directed();
    test_random_sprites(100);
    test_extreme_matrix();
    test_random_configs();
    drain();
    if (mismatches == 0 && vertex_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
